// File: hdl/ffha_pkg.sv
// ffha_pkg: shared types and codes for the first-fit heap allocator
// payload structs, result status codes, controller/datapath command and status
// no dependencies
`default_nettype none

package ffha_pkg;

	localparam int unsigned SIZE_W  = 22;
	localparam int unsigned COUNT_W = 23;
	localparam int unsigned PAD_BYTES = 4;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] HEAP_RESET = 23'd1048576;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NULL      = 3'd1,
		ST_NO_MEMORY = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_BAD_FREE  = 3'd4
	} status_t;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef struct packed {
		logic              kind;
		logic [SIZE_W-1:0] request_bytes;
		logic [SIZE_W-1:0] payload_offset;
	} ffha_in_t;

	typedef struct packed {
		status_t            status;
		logic [SIZE_W-1:0]  result_offset;
		logic               was_reused;
		logic [COUNT_W-1:0] bytes_used;
	} ffha_out_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_WALK = 2'd1
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} ffha_cmd_t;

	typedef struct packed {
		logic zero_req;
		logic walk_end;
		logic hit;
	} ffha_sts_t;

endpackage

`default_nettype wire

// File: hdl/ffha_ctrl.sv
// ffha_ctrl: request sequencer for the first-fit heap allocator
// accepts a request, steps the block walk, commits and owns the result valid
// depends on ffha_pkg
`default_nettype none

module ffha_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	input  ffha_pkg::ffha_sts_t sts,
	output ffha_pkg::ffha_cmd_t cmd
);
	import ffha_pkg::*;

	ctrl_state_t state_q, state_nxt;
	logic        rsp_valid_q;
	logic        done;
	logic        out_free;

	assign done     = sts.zero_req || sts.walk_end || sts.hit;
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid)
					state_nxt = S_WALK;
			end
			S_WALK: begin
				if (done && out_free)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = req_valid;
			end
			S_WALK: begin
				cmd.finish = done && out_free;
				cmd.step   = !done;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

// File: hdl/ffha_dp.sv
// ffha_dp: datapath of the first-fit heap allocator
// block size memory, busy flags, walk offset, heap top, byte count, result register
// depends on ffha_pkg
`default_nettype none

module ffha_dp #(
	parameter int unsigned MAX_BLOCKS   = 64,
	parameter int unsigned HEADER_BYTES = 8,
	parameter int unsigned OFFSET_BITS  = 22
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [ffha_pkg::COUNT_W-1:0]  cfg_wdata,
	input  ffha_pkg::ffha_in_t            req,
	input  ffha_pkg::ffha_cmd_t           cmd,
	output ffha_pkg::ffha_sts_t           sts,
	output ffha_pkg::ffha_out_t           rsp
);
	import ffha_pkg::*;

	localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
	localparam logic [4:0] HDR = 5'(HEADER_BYTES);
	localparam logic [5:0] SPAN_EXTRA = 6'(HEADER_BYTES + PAD_BYTES);
	localparam longint unsigned OFF_MASK_L = (64'd1 << OFFSET_BITS) - 64'd1;
	localparam logic [23:0] OFF_MASK = 24'(OFF_MASK_L);

	logic [SIZE_W-1:0]  mem [MAX_BLOCKS];
	logic [SIZE_W-1:0]  size_rd_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               wr_en;

	logic [MAX_BLOCKS-1:0] busy_q;
	logic [CNT_W-1:0]      total_q;
	logic [CNT_W-1:0]      cur_q;
	logic [CNT_W-1:0]      cur_inc;
	logic [COUNT_W-1:0]    pos_q;
	logic [COUNT_W-1:0]    top_q;
	logic [COUNT_W-1:0]    used_q;
	logic [COUNT_W-1:0]    heap_q;

	logic                  kind_q;
	logic [SIZE_W-1:0]     req_bytes_q;
	logic [SIZE_W-1:0]     target_q;

	logic                  is_free;
	logic                  cur_busy;
	logic [IDX_W-1:0]      cur_idx;
	logic [23:0]           pos_hdr;
	logic [23:0]           free_sub;
	logic [COUNT_W-1:0]    used_after_free;
	logic [24:0]           reuse_sum;
	logic [24:0]           append_sum;
	logic [COUNT_W-1:0]    used_after_reuse;
	logic [COUNT_W-1:0]    used_after_append;
	logic [24:0]           top_req_hdr;
	logic [24:0]           new_top;
	logic [23:0]           payload;
	logic                  no_memory;
	logic                  table_full;
	logic                  append_ok;
	logic                  free_hit;
	logic                  alloc_hit;

	assign is_free  = (kind_q == KIND_FREE);
	assign cur_idx  = cur_q[IDX_W-1:0];
	assign cur_busy = busy_q[cur_idx];
	assign cur_inc  = cur_q + CNT_W'(1);

	assign pos_hdr   = {1'b0, pos_q} + 24'(HDR);
	assign free_hit  = is_free && (pos_hdr == {2'b00, target_q});
	assign alloc_hit = !is_free && !cur_busy && (size_rd_q >= req_bytes_q);

	assign sts.zero_req = !is_free && (req_bytes_q == '0);
	assign sts.walk_end = (cur_q == total_q);
	assign sts.hit      = (cur_q != total_q) && (free_hit || alloc_hit);

	// freeing subtracts stored size plus header, floor at zero
	assign free_sub        = {2'b00, size_rd_q} + 24'(HDR);
	assign used_after_free = ({1'b0, used_q} > free_sub)
		? COUNT_W'({1'b0, used_q} - free_sub) : '0;

	assign reuse_sum        = {2'b00, used_q} + {3'b000, req_bytes_q} + 25'(HDR);
	assign used_after_reuse = (reuse_sum > {2'b00, COUNT_MAX})
		? COUNT_MAX : reuse_sum[COUNT_W-1:0];
	assign append_sum        = reuse_sum + 25'(PAD_BYTES);
	assign used_after_append = (append_sum > {2'b00, COUNT_MAX})
		? COUNT_MAX : append_sum[COUNT_W-1:0];

	assign top_req_hdr = {2'b00, top_q} + {3'b000, req_bytes_q} + 25'(HDR);
	assign new_top     = top_req_hdr + 25'(PAD_BYTES);
	assign payload     = {1'b0, top_q} + 24'(HDR);
	assign no_memory   = (top_req_hdr >= {2'b00, heap_q})
		|| (new_top > {2'b00, COUNT_MAX})
		|| ((payload & ~OFF_MASK) != '0);
	assign table_full  = (total_q >= CNT_MAX);
	assign append_ok   = !is_free && !sts.zero_req && sts.walk_end
		&& !no_memory && !table_full;
	assign wr_en       = cmd.finish && append_ok;

	always_comb begin
		if (cmd.load)
			rd_addr = '0;
		else if (cmd.step)
			rd_addr = cur_inc[IDX_W-1:0];
		else
			rd_addr = cur_idx;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[total_q[IDX_W-1:0]] <= req_bytes_q;
	end

	always_ff @(posedge clk) begin
		size_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q      <= req.kind;
			req_bytes_q <= req.request_bytes;
			target_q    <= req.payload_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			pos_q <= '0;
		end else if (cmd.load) begin
			cur_q <= '0;
			pos_q <= '0;
		end else if (cmd.step) begin
			cur_q <= cur_inc;
			pos_q <= pos_q + {1'b0, size_rd_q} + COUNT_W'(SPAN_EXTRA);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q <= HEAP_RESET;
		end else if (cfg_we) begin
			heap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			total_q <= '0;
			top_q   <= '0;
			used_q  <= '0;
		end else if (cmd.finish) begin
			if (is_free) begin
				if (sts.hit) begin
					busy_q[cur_idx] <= 1'b0;
					used_q          <= used_after_free;
				end
			end else if (!sts.zero_req) begin
				if (sts.hit) begin
					busy_q[cur_idx] <= 1'b1;
					used_q          <= used_after_reuse;
				end else if (append_ok) begin
					busy_q[total_q[IDX_W-1:0]] <= 1'b1;
					total_q <= total_q + CNT_W'(1);
					top_q   <= new_top[COUNT_W-1:0];
					used_q  <= used_after_append;
				end
			end
		end
	end

	// result register, loaded with the post-request count
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (is_free) begin
				rsp.status        <= sts.hit ? ST_OK : ST_BAD_FREE;
				rsp.result_offset <= '0;
				rsp.was_reused    <= 1'b0;
				rsp.bytes_used    <= sts.hit ? used_after_free : used_q;
			end else if (sts.zero_req) begin
				rsp.status        <= ST_NULL;
				rsp.result_offset <= '0;
				rsp.was_reused    <= 1'b0;
				rsp.bytes_used    <= used_q;
			end else if (sts.hit) begin
				rsp.status        <= ST_OK;
				rsp.result_offset <= SIZE_W'(pos_hdr & OFF_MASK);
				rsp.was_reused    <= 1'b1;
				rsp.bytes_used    <= used_after_reuse;
			end else if (no_memory) begin
				rsp.status        <= ST_NO_MEMORY;
				rsp.result_offset <= '0;
				rsp.was_reused    <= 1'b0;
				rsp.bytes_used    <= used_q;
			end else if (table_full) begin
				rsp.status        <= ST_TABLE_FULL;
				rsp.result_offset <= '0;
				rsp.was_reused    <= 1'b0;
				rsp.bytes_used    <= used_q;
			end else begin
				rsp.status        <= ST_OK;
				rsp.result_offset <= SIZE_W'(payload & OFF_MASK);
				rsp.was_reused    <= 1'b0;
				rsp.bytes_used    <= used_after_append;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/first_fit_heap_allocator_unit.sv
// first_fit_heap_allocator_unit: first-fit heap allocator, top level
// a request walks the table to a hit, a zero size or the end; then its result is registered
// throughput: one request at a time; one size table entry read per cycle
// a finished result waits in an output register while the next request is taken
// reset: async active low; busy flags, block count, heap top and byte count clear,
// heap size returns to 1048576, size table contents undefined until written
`default_nettype none

module first_fit_heap_allocator_unit #(
	parameter int unsigned MAX_BLOCKS   = 64,
	parameter int unsigned HEADER_BYTES = 8,
	parameter int unsigned OFFSET_BITS  = 22
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [ffha_pkg::COUNT_W-1:0] cfg_wdata,
	input  wire                          req_valid,
	output logic                         req_stall,
	input  ffha_pkg::ffha_in_t           req,
	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	output ffha_pkg::ffha_out_t          rsp
);
	import ffha_pkg::*;

	ffha_cmd_t cmd;
	ffha_sts_t sts;

	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffha_dp #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES),
		.OFFSET_BITS  (OFFSET_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
